@@ rtl/core/spsh_pkg.sv @@
// Shared types and defaults for the segment-point harmonic spring kernel.
package spsh_pkg;

    localparam int SPSH_COORD_WIDTH = 32;

    typedef struct packed {
        logic signed [31:0] first_end_x;
        logic signed [31:0] first_end_y;
        logic signed [31:0] first_end_z;
        logic signed [31:0] second_end_x;
        logic signed [31:0] second_end_y;
        logic signed [31:0] second_end_z;
        logic signed [31:0] partner_x;
        logic signed [31:0] partner_y;
        logic signed [31:0] partner_z;
        logic        [16:0] fraction_along;
        logic        [31:0] spring_constant;
        logic        [30:0] rest_length;
    } t_cmd;

    typedef struct packed {
        logic        [47:0] spring_energy;
        logic signed [31:0] push_first_x;
        logic signed [31:0] push_first_y;
        logic signed [31:0] push_first_z;
        logic signed [31:0] push_second_x;
        logic signed [31:0] push_second_y;
        logic signed [31:0] push_second_z;
        logic signed [31:0] push_partner_x;
        logic signed [31:0] push_partner_y;
        logic signed [31:0] push_partner_z;
        logic               zero_length_flag;
    } t_rsp;

endpackage

@@ rtl/core/spsh_dly.sv @@
// Fixed-length delay line that keeps side data aligned with the pipeline.
module spsh_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_sh [N];

    always_ff @(posedge i_clk) begin
        r_sh[0] <= i_d;
        for (int i = 1; i < N; i++) begin
            r_sh[i] <= r_sh[i-1];
        end
    end

    assign o_q = r_sh[N-1];
endmodule

@@ rtl/core/spsh_mul.sv @@
// Two-stage unsigned multiplier built from four registered partial products.
module spsh_mul #(
    parameter int AW = 64,
    parameter int BW = 48
) (
    input  logic             i_clk,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic [AW+BW-1:0] o_p
);
    localparam int AL = AW / 2;
    localparam int AH = AW - AL;
    localparam int BL = BW / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic [AL+BL-1:0] r_p00;
    logic [AL+BH-1:0] r_p01;
    logic [AH+BL-1:0] r_p10;
    logic [AH+BH-1:0] r_p11;
    logic [PW-1:0]    r_p;
    logic [PW-1:0]    n_p;

    always_ff @(posedge i_clk) begin
        r_p00 <= i_a[AL-1:0] * i_b[BL-1:0];
        r_p01 <= i_a[AL-1:0] * i_b[BW-1:BL];
        r_p10 <= i_a[AW-1:AL] * i_b[BL-1:0];
        r_p11 <= i_a[AW-1:AL] * i_b[BW-1:BL];
        r_p   <= n_p;
    end

    always_comb begin
        n_p = (PW'(r_p11) << (AL + BL)) + (PW'(r_p01) << BL)
            + (PW'(r_p10) << AL) + PW'(r_p00);
    end

    assign o_p = r_p;
endmodule

@@ rtl/core/spsh_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module spsh_sqrt #(
    parameter int IN_W  = 66,
    parameter int OUT_W = 33
) (
    input  logic             i_clk,
    input  logic [IN_W-1:0]  i_s,
    output logic [OUT_W-1:0] o_root
);
    localparam int RW = IN_W + 2;

    logic [RW-1:0]    r_rem [OUT_W];
    logic [OUT_W-1:0] r_res [OUT_W];

    genvar g;
    generate
        for (g = 0; g < OUT_W; g++) begin : g_stage
            localparam int B = OUT_W - 1 - g;
            logic [RW-1:0]    w_rem;
            logic [OUT_W-1:0] w_res;
            logic [RW-1:0]    n_try;

            if (g == 0) begin : g_first
                assign w_rem = RW'(i_s);
                assign w_res = '0;
            end else begin : g_next
                assign w_rem = r_rem[g-1];
                assign w_res = r_res[g-1];
            end

            // step from res^2 to (res + 2^B)^2
            assign n_try = (RW'(w_res) << (B + 1)) + (RW'(1) << (2 * B));

            always_ff @(posedge i_clk) begin
                if (n_try <= w_rem) begin
                    r_rem[g] <= w_rem - n_try;
                    r_res[g] <= w_res | (OUT_W'(1) << B);
                end else begin
                    r_rem[g] <= w_rem;
                    r_res[g] <= w_res;
                end
            end
        end
    endgenerate

    assign o_root = r_res[OUT_W-1];
endmodule

@@ rtl/core/spsh_div.sv @@
// Pipelined restoring divider with an overflow flag for quotients past Q_W bits.
module spsh_div #(
    parameter int N_W = 83,
    parameter int D_W = 33,
    parameter int Q_W = 32
) (
    input  logic           i_clk,
    input  logic [N_W-1:0] i_n,
    input  logic [D_W-1:0] i_d,
    output logic [Q_W-1:0] o_q,
    output logic           o_ovf
);
    logic [D_W-1:0] r_rem [Q_W+1];
    logic [Q_W-1:0] r_lo  [Q_W+1];
    logic [Q_W-1:0] r_q   [Q_W+1];
    logic [D_W-1:0] r_d   [Q_W+1];
    logic           r_ovf [Q_W+1];

    // upper part decides overflow; below it the partial remainder is under d
    always_ff @(posedge i_clk) begin
        r_ovf[0] <= (i_n[N_W-1:Q_W] >= (N_W-Q_W)'(i_d));
        r_rem[0] <= i_n[Q_W+D_W-1:Q_W];
        r_lo[0]  <= i_n[Q_W-1:0];
        r_q[0]   <= '0;
        r_d[0]   <= i_d;
    end

    genvar g;
    generate
        for (g = 1; g <= Q_W; g++) begin : g_step
            logic [D_W:0] n_rem;
            assign n_rem = {r_rem[g-1], r_lo[g-1][Q_W-1]};

            always_ff @(posedge i_clk) begin
                r_lo[g]  <= r_lo[g-1] << 1;
                r_d[g]   <= r_d[g-1];
                r_ovf[g] <= r_ovf[g-1];
                if (n_rem >= {1'b0, r_d[g-1]}) begin
                    r_rem[g] <= D_W'(n_rem - {1'b0, r_d[g-1]});
                    r_q[g]   <= {r_q[g-1][Q_W-2:0], 1'b1};
                end else begin
                    r_rem[g] <= n_rem[D_W-1:0];
                    r_q[g]   <= {r_q[g-1][Q_W-2:0], 1'b0};
                end
            end
        end
    endgenerate

    assign o_q   = r_q[Q_W];
    assign o_ovf = r_ovf[Q_W];
endmodule

@@ rtl/core/segment_point_harmonic_spring.sv @@
// Top level: harmonic spring between a point on a segment and a third bead.
//
// Fully pipelined kernel: a transaction may start on every clock cycle and busy
// stays low. Each result appears on o_rsp with o_valid high; the receiver cannot
// stall, so it must take the result in that cycle. Most of the pipeline is the
// 33-stage square root of the squared distance and the 33-stage dividers that
// scale the nine force components by the distance.
// Energy and forces saturate; a zero distance sets zero_length_flag and zeroes
// all forces. COORD_WIDTH (taken as 16..32) sets how many low coordinate bits
// are used and the saturation range of the forces.
module segment_point_harmonic_spring
    import spsh_pkg::*;
#(
    parameter int COORD_WIDTH = SPSH_COORD_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_cmd i_cmd,
    output logic o_valid,
    output t_rsp o_rsp
);
    localparam int CW  = (COORD_WIDTH < 16) ? 16 : ((COORD_WIDTH > 32) ? 32 : COORD_WIDTH);
    localparam int SH  = 32 - CW;
    localparam int LAT = 77;

    logic [LAT-1:0] r_vld;

    // input decode
    logic signed [31:0] n_a [3];
    logic signed [31:0] n_b [3];
    logic signed [31:0] n_c [3];
    logic        [16:0] n_p;

    always_comb begin
        n_a[0] = $signed(i_cmd.first_end_x  << SH) >>> SH;
        n_a[1] = $signed(i_cmd.first_end_y  << SH) >>> SH;
        n_a[2] = $signed(i_cmd.first_end_z  << SH) >>> SH;
        n_b[0] = $signed(i_cmd.second_end_x << SH) >>> SH;
        n_b[1] = $signed(i_cmd.second_end_y << SH) >>> SH;
        n_b[2] = $signed(i_cmd.second_end_z << SH) >>> SH;
        n_c[0] = $signed(i_cmd.partner_x    << SH) >>> SH;
        n_c[1] = $signed(i_cmd.partner_y    << SH) >>> SH;
        n_c[2] = $signed(i_cmd.partner_z    << SH) >>> SH;
        n_p    = (i_cmd.fraction_along > 17'd65536) ? 17'd65536 : i_cmd.fraction_along;
    end

    // stages 1..3: interpolated point and separation vector
    logic signed [49:0] r_ma [3];
    logic signed [49:0] r_mb [3];
    logic signed [31:0] r_c1 [3];
    logic signed [31:0] r_c2 [3];
    logic signed [50:0] r_acc [3];
    logic        [16:0] r_p1, r_p2, r_p3;
    logic        [31:0] r_ar3 [3];
    logic        [2:0]  r_rneg3;
    logic signed [33:0] n_r [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_r[i] = 34'(r_c2[i]) - 34'($signed(r_acc[i][47:16]));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_ma[i]   <= n_a[i] * $signed({1'b0, 17'(17'd65536 - n_p)});
            r_mb[i]   <= n_b[i] * $signed({1'b0, n_p});
            r_c1[i]   <= n_c[i];
            r_acc[i]  <= 51'(r_ma[i]) + 51'(r_mb[i]) + 51'sd32768;
            r_c2[i]   <= r_c1[i];
            r_ar3[i]  <= n_r[i][33] ? 32'(-n_r[i]) : 32'(n_r[i]);
            r_rneg3[i] <= n_r[i][33];
        end
        r_p1 <= n_p;
        r_p2 <= r_p1;
        r_p3 <= r_p2;
    end

    // stage 4/5: squares, lane weights, squared distance
    logic [63:0]        r_sq4 [3];
    logic [8:0][48:0]   r_y4;
    logic [65:0]        r_sum5;
    logic [16:0]        n_w [3];

    always_comb begin
        n_w[0] = 17'd65536 - r_p3;
        n_w[1] = r_p3;
        n_w[2] = 17'd65536;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_sq4[i] <= r_ar3[i] * r_ar3[i];
            for (int j = 0; j < 3; j++) begin
                r_y4[3*j+i] <= r_ar3[i] * n_w[j];
            end
        end
        r_sum5 <= 66'(r_sq4[0]) + 66'(r_sq4[1]) + 66'(r_sq4[2]);
    end

    // stages 6..38: distance
    logic [32:0] w_len38;
    spsh_sqrt #(.IN_W(66), .OUT_W(33)) u_sqrt (
        .i_clk  (i_clk),
        .i_s    (r_sum5),
        .o_root (w_len38)
    );

    logic [30:0] w_l0_38;
    logic [31:0] w_k39;
    spsh_dly #(.W(31), .N(38)) u_dly_l0 (
        .i_clk (i_clk), .i_d (i_cmd.rest_length), .o_q (w_l0_38)
    );
    spsh_dly #(.W(32), .N(39)) u_dly_k (
        .i_clk (i_clk), .i_d (i_cmd.spring_constant), .o_q (w_k39)
    );

    // stage 39: stretch
    logic signed [33:0] n_e;
    logic [32:0] r_ae39, r_len39;
    logic        r_eneg39, r_zero39;

    assign n_e = $signed({1'b0, w_len38}) - $signed({3'b0, w_l0_38});

    always_ff @(posedge i_clk) begin
        r_ae39   <= n_e[33] ? 33'(-n_e) : 33'(n_e);
        r_eneg39 <= n_e[33];
        r_len39  <= w_len38;
        r_zero39 <= (w_len38 == '0);
    end

    // stage 40: k*|e| and |e|^2
    logic [64:0] r_x40;
    logic [65:0] r_ae2_40;
    logic [31:0] r_k40;

    always_ff @(posedge i_clk) begin
        r_x40    <= r_ae39 * w_k39;
        r_ae2_40 <= r_ae39 * r_ae39;
        r_k40    <= w_k39;
    end

    logic [8:0][48:0] w_y40;
    spsh_dly #(.W(9*49), .N(36)) u_dly_y (
        .i_clk (i_clk), .i_d (r_y4), .o_q (w_y40)
    );

    // stages 41..42: force numerators and energy product
    logic [113:0] w_num42 [9];
    logic [97:0]  w_en42;

    genvar g;
    generate
        for (g = 0; g < 9; g++) begin : g_num
            spsh_mul #(.AW(65), .BW(49)) u_mul (
                .i_clk (i_clk),
                .i_a   (r_x40),
                .i_b   (w_y40[g]),
                .o_p   (w_num42[g])
            );
        end
    endgenerate

    spsh_mul #(.AW(66), .BW(32)) u_mul_en (
        .i_clk (i_clk),
        .i_a   (r_ae2_40),
        .i_b   (r_k40),
        .o_p   (w_en42)
    );

    logic [32:0] w_len42;
    spsh_dly #(.W(33), .N(3)) u_dly_len (
        .i_clk (i_clk), .i_d (r_len39), .o_q (w_len42)
    );

    // stage 43: round numerators, finish energy
    logic [82:0]  r_t43 [9];
    logic [47:0]  r_en43;
    logic [32:0]  r_len43;
    logic [114:0] n_t [9];
    logic [98:0]  n_en;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            n_t[i] = 115'(w_num42[i]) + (115'(w_len42) << 31);
        end
        n_en = 99'(w_en42) + (99'(1) << 24);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 9; i++) begin
            r_t43[i] <= n_t[i][114:32];
        end
        r_en43  <= (n_en[98:73] != '0) ? '1 : n_en[72:25];
        r_len43 <= w_len42;
    end

    // stages 44..76: divide by distance
    logic [31:0] w_q76 [9];
    logic        w_ovf76 [9];

    generate
        for (g = 0; g < 9; g++) begin : g_div
            spsh_div #(.N_W(83), .D_W(33), .Q_W(32)) u_div (
                .i_clk (i_clk),
                .i_n   (r_t43[g]),
                .i_d   (r_len43),
                .o_q   (w_q76[g]),
                .o_ovf (w_ovf76[g])
            );
        end
    endgenerate

    logic [2:0]  w_rneg76;
    logic [1:0]  w_ez76;
    logic [47:0] w_en76;
    spsh_dly #(.W(3), .N(73)) u_dly_rneg (
        .i_clk (i_clk), .i_d (r_rneg3), .o_q (w_rneg76)
    );
    spsh_dly #(.W(2), .N(37)) u_dly_ez (
        .i_clk (i_clk), .i_d ({r_eneg39, r_zero39}), .o_q (w_ez76)
    );
    spsh_dly #(.W(48), .N(33)) u_dly_en (
        .i_clk (i_clk), .i_d (r_en43), .o_q (w_en76)
    );

    // stage 77: sign, saturate, output register
    logic [31:0] n_f [9];
    logic        n_neg;
    logic [31:0] n_lim;
    logic [31:0] n_m;
    t_rsp        r_rsp;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                n_neg = (w_ez76[1] != w_rneg76[i]) ^ (j == 2);
                n_lim = (32'(1) << (CW - 1)) - (n_neg ? 32'd0 : 32'd1);
                n_m   = (w_ovf76[3*j+i] || (w_q76[3*j+i] > n_lim)) ? n_lim : w_q76[3*j+i];
                n_f[3*j+i] = w_ez76[0] ? 32'd0 : (n_neg ? -n_m : n_m);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp.spring_energy    <= w_en76;
        r_rsp.push_first_x     <= n_f[0];
        r_rsp.push_first_y     <= n_f[1];
        r_rsp.push_first_z     <= n_f[2];
        r_rsp.push_second_x    <= n_f[3];
        r_rsp.push_second_y    <= n_f[4];
        r_rsp.push_second_z    <= n_f[5];
        r_rsp.push_partner_x   <= n_f[6];
        r_rsp.push_partner_y   <= n_f[7];
        r_rsp.push_partner_z   <= n_f[8];
        r_rsp.zero_length_flag <= w_ez76[0];
    end

    // advance the valid marks with their transactions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
        end
    end

    assign busy    = 1'b0;
    assign o_valid = r_vld[LAT-1];
    assign o_rsp   = r_rsp;
endmodule
